FILE: design/rcc_pkg.sv
// Shared constants and types for radius connected clustering.
package rcc_pkg;
	localparam int MaxPoints = 64;
	localparam int CoordBits = 24;
	localparam int IdxBits = $clog2(MaxPoints);
	localparam int CntBits = $clog2(MaxPoints + 1);
	localparam int RadBits = 23;
	localparam int DiffBits = CoordBits + 1;
	localparam int SqBits = 2 * RadBits + 1;
	localparam logic [RadBits-1:0] RadiusReset = RadBits'(160);

	typedef logic signed [CoordBits-1:0] coord_t;
	typedef logic [IdxBits-1:0] idx_t;
	typedef logic [CntBits-1:0] cnt_t;
	typedef logic [RadBits-1:0] rad_t;

	// request to / answer from the shared link unit
	typedef struct packed {
		logic go;
		coord_t ax;
		coord_t ay;
		coord_t bx;
		coord_t by;
	} link_req_t;

	typedef struct packed {
		logic done;
		logic linked;
	} link_rsp_t;
endpackage

FILE: design/rcc_link_unit.sv
// Shared distance unit: pipelined squared-distance compare of two points.
module rcc_link_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  rcc_pkg::rad_t     radius,
	input  rcc_pkg::link_req_t req,
	output rcc_pkg::link_rsp_t rsp
);
	import rcc_pkg::*;

	logic [DiffBits-1:0] dx_s1, dy_s1;
	logic v_s1, v_s2, v_s3;
	logic far_s2, far_s3;
	logic [SqBits-2:0] sx_s2, sy_s2;
	logic [SqBits-1:0] sum_s3;
	logic [SqBits-2:0] rr_s2, rr_s3;
	logic signed [DiffBits-1:0] ddx, ddy;

	assign ddx = DiffBits'(req.ax) - DiffBits'(req.bx);
	assign ddy = DiffBits'(req.ay) - DiffBits'(req.by);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= req.go;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1 <= ddx[DiffBits-1] ? DiffBits'(-ddx) : ddx;
		dy_s1 <= ddy[DiffBits-1] ? DiffBits'(-ddy) : ddy;
		far_s2 <= (dx_s1 > DiffBits'(radius)) || (dy_s1 > DiffBits'(radius));
		sx_s2 <= (SqBits-1)'(RadBits'(dx_s1)) * (SqBits-1)'(RadBits'(dx_s1));
		sy_s2 <= (SqBits-1)'(RadBits'(dy_s1)) * (SqBits-1)'(RadBits'(dy_s1));
		rr_s2 <= (SqBits-1)'(radius) * (SqBits-1)'(radius);
		far_s3 <= far_s2;
		sum_s3 <= SqBits'(sx_s2) + SqBits'(sy_s2);
		rr_s3 <= rr_s2;
	end

	assign rsp.done = v_s3;
	assign rsp.linked = !far_s3 && (sum_s3 <= SqBits'(rr_s3));
endmodule

FILE: design/radius_connected_clustering.sv
// Top level: point store, clustering sequencer and result emission.
// Usage: write radius on cfg_valid/cfg_ready (ready only while idle).
// Points enter with start when busy is low, one per cycle while loading.
// A point with last_point high starts clustering; busy stays high until
// every loaded point has been emitted, one result per strobe cycle.
// Results leave area by area in join order, area_id counting from 0.
// Clustering: a seed scan over the points; per member the order entry and the
// point are fetched, then each loaded point is skipped if already taken, else
// read and compared in the three-stage distance unit before the next fetch.
// Emission runs the emit, pointer and output states per result, then loads again.
// Points and join order sit in memories with registered reads.
// Points beyond 64 are dropped and overflow is set on every result.
// Reset clears all control state and sets radius to 160; no clearing pass.
// The receiver cannot stall; each result shows for exactly one cycle.
module radius_connected_clustering (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  rcc_pkg::coord_t   x_coord,
	input  rcc_pkg::coord_t   y_coord,
	input  logic              last_point,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  rcc_pkg::rad_t     cfg_data,
	output logic              strobe,
	output rcc_pkg::idx_t     point_index,
	output rcc_pkg::coord_t   x_out,
	output rcc_pkg::coord_t   y_out,
	output rcc_pkg::idx_t     area_id,
	output logic              last_in_area,
	output logic              last_result,
	output logic              overflow
);
	import rcc_pkg::*;

	typedef enum logic [3:0] {
		ST_LOAD, ST_SEED, ST_HEAD, ST_HPTR, ST_HLOAD, ST_FETCH, ST_READ, ST_WAIT,
		ST_EMIT, ST_EPTR, ST_EOUT
	} state_t;

	state_t state_q;
	coord_t mem_x [MaxPoints];
	coord_t mem_y [MaxPoints];
	idx_t order_q [MaxPoints];
	logic [MaxPoints-1:0] taken_q;
	logic [MaxPoints-1:0] area_end_q;
	rad_t radius_q;
	cnt_t n_q, k_q, head_q, seed_q, j_q, emit_q;
	idx_t emit_area_q;
	logic ovf_q;
	coord_t hx_q, hy_q;
	coord_t rd_x_q, rd_y_q;
	idx_t ord_q;
	idx_t ord_addr, mem_addr, ord_wdata;
	logic ord_we;
	link_req_t req;
	link_rsp_t rsp;

	assign busy = (state_q != ST_LOAD);
	assign cfg_ready = !busy;

	assign req.go = (state_q == ST_READ);
	assign req.ax = hx_q;
	assign req.ay = hy_q;
	assign req.bx = rd_x_q;
	assign req.by = rd_y_q;

	rcc_link_unit u_link (
		.clk(clk), .arst_n(arst_n), .radius(radius_q), .req(req), .rsp(rsp)
	);

	always_comb begin
		if (state_q inside {ST_EMIT, ST_EPTR, ST_EOUT})
			ord_addr = emit_q[IdxBits-1:0];
		else
			ord_addr = head_q[IdxBits-1:0];
		case (state_q)
			ST_HPTR, ST_EPTR: mem_addr = ord_q;
			default: mem_addr = j_q[IdxBits-1:0];
		endcase
		ord_we = (state_q == ST_SEED && seed_q != n_q && !taken_q[seed_q[IdxBits-1:0]]) ||
			(state_q == ST_WAIT && rsp.done && rsp.linked);
		ord_wdata = (state_q == ST_SEED) ? seed_q[IdxBits-1:0] : j_q[IdxBits-1:0];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD && start && n_q < cnt_t'(MaxPoints)) begin
			mem_x[n_q[IdxBits-1:0]] <= x_coord;
			mem_y[n_q[IdxBits-1:0]] <= y_coord;
		end
		rd_x_q <= mem_x[mem_addr];
		rd_y_q <= mem_y[mem_addr];
	end

	always_ff @(posedge clk) begin
		if (ord_we) order_q[k_q[IdxBits-1:0]] <= ord_wdata;
		ord_q <= order_q[ord_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			radius_q <= RadiusReset;
			taken_q <= '0;
			area_end_q <= '0;
			n_q <= '0;
			k_q <= '0;
			head_q <= '0;
			seed_q <= '0;
			j_q <= '0;
			emit_q <= '0;
			emit_area_q <= '0;
			ovf_q <= 1'b0;
			hx_q <= '0;
			hy_q <= '0;
			strobe <= 1'b0;
			point_index <= '0;
			x_out <= '0;
			y_out <= '0;
			area_id <= '0;
			last_in_area <= 1'b0;
			last_result <= 1'b0;
			overflow <= 1'b0;
		end else begin
			strobe <= 1'b0;
			case (state_q)
				ST_LOAD: begin
					if (cfg_valid) radius_q <= cfg_data;
					if (start) begin
						if (n_q < cnt_t'(MaxPoints)) n_q <= n_q + 1'b1;
						else ovf_q <= 1'b1;
						if (last_point) begin
							seed_q <= '0;
							k_q <= '0;
							state_q <= ST_SEED;
						end
					end
				end
				ST_SEED: begin
					if (seed_q == n_q) begin
						emit_q <= '0;
						emit_area_q <= '0;
						state_q <= ST_EMIT;
					end else if (taken_q[seed_q[IdxBits-1:0]]) begin
						seed_q <= seed_q + 1'b1;
					end else begin
						taken_q[seed_q[IdxBits-1:0]] <= 1'b1;
						k_q <= k_q + 1'b1;
						head_q <= k_q;
						seed_q <= seed_q + 1'b1;
						state_q <= ST_HEAD;
					end
				end
				ST_HEAD: begin
					if (head_q == k_q) begin
						area_end_q[k_q[IdxBits-1:0] - 1'b1] <= 1'b1;
						state_q <= ST_SEED;
					end else begin
						state_q <= ST_HPTR;
					end
				end
				ST_HPTR: state_q <= ST_HLOAD;
				ST_HLOAD: begin
					hx_q <= rd_x_q;
					hy_q <= rd_y_q;
					j_q <= '0;
					state_q <= ST_FETCH;
				end
				ST_FETCH: begin
					if (j_q == n_q) begin
						head_q <= head_q + 1'b1;
						state_q <= ST_HEAD;
					end else if (taken_q[j_q[IdxBits-1:0]]) begin
						j_q <= j_q + 1'b1;
					end else begin
						state_q <= ST_READ;
					end
				end
				ST_READ: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (rsp.done) begin
						if (rsp.linked) begin
							taken_q[j_q[IdxBits-1:0]] <= 1'b1;
							k_q <= k_q + 1'b1;
						end
						j_q <= j_q + 1'b1;
						state_q <= ST_FETCH;
					end
				end
				ST_EMIT: begin
					if (emit_q == k_q) begin
						taken_q <= '0;
						area_end_q <= '0;
						n_q <= '0;
						ovf_q <= 1'b0;
						state_q <= ST_LOAD;
					end else begin
						state_q <= ST_EPTR;
					end
				end
				ST_EPTR: state_q <= ST_EOUT;
				ST_EOUT: begin
					strobe <= 1'b1;
					point_index <= ord_q;
					x_out <= rd_x_q;
					y_out <= rd_y_q;
					area_id <= emit_area_q;
					last_in_area <= area_end_q[emit_q[IdxBits-1:0]];
					last_result <= (emit_q + 1'b1 == k_q);
					overflow <= ovf_q;
					if (area_end_q[emit_q[IdxBits-1:0]])
						emit_area_q <= emit_area_q + 1'b1;
					emit_q <= emit_q + 1'b1;
					state_q <= ST_EMIT;
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end
endmodule

FILE: design/rcc_checker.sv
// Port-level checks for radius connected clustering, bound to the top level.
module rcc_checker (
	input logic clk,
	input logic arst_n,
	input logic busy,
	input logic start,
	input logic last_point,
	input logic cfg_ready,
	input logic strobe,
	input logic last_result,
	input logic last_in_area
);
	a_no_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy)) else $error("result while idle");
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready |-> !busy) else $error("cfg ready while busy");
	a_last_ends_area: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last_result |-> last_in_area) else $error("last not area end");
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && last_point |=> busy) else $error("no clustering");
endmodule

bind radius_connected_clustering rcc_checker u_rcc_checker (
	.clk(clk), .arst_n(arst_n), .busy(busy), .start(start),
	.last_point(last_point), .cfg_ready(cfg_ready), .strobe(strobe),
	.last_result(last_result), .last_in_area(last_in_area)
);
